// ===== src/tss_pkg.sv =====
package tss_pkg;

  localparam int CW = 17;
  localparam int UW = 16;
  localparam int SQB = 26;
  localparam int XW = 2 * SQB;
  localparam int QB = 15;
  localparam int NW = 42;
  localparam int FRAC_SHIFT = 23;
  localparam int NORM_LAT = SQB + QB + 4;

  localparam logic [QB-1:0] UNIT_Q14 = 15'd16384;
  localparam logic [7:0] LIGHT_SCALE = 8'd210;
  localparam logic [10:0] LIGHT_MAX = 11'd1024;
  localparam logic [17:0] SHALLOW_LIMIT = 18'd2560;
  localparam logic [7:0] BYTE_MAX = 8'd255;
  localparam logic [15:0] RECIP5 = 16'd52429;
  localparam int RECIP5_SHIFT = 18;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [UW-1:0] unit_t;

  typedef enum logic [2:0] {
    REG_SUN_DIRECTION    = 3'd0,
    REG_SUN_COLOR        = 3'd1,
    REG_AMBIENT_COLOR    = 3'd2,
    REG_WATER_MIN_COLOR  = 3'd3,
    REG_WATER_BASE_COLOR = 3'd4,
    REG_WATER_ABSORB     = 3'd5
  } cfg_reg_t;

endpackage

// ===== src/terrain_square_shader.sv =====
// A result word passes through two 45-stage normalizers in series, 9 shading
// stages and one output register. Throughput: one word per cycle unless
// m_tready stalls the output; the bit-per-stage square root and divider
// pipelines inside each normalizer set the depth.
// Reset clears all valid bits and the configuration registers to zero.
module terrain_square_shader import tss_pkg::*; #(
  parameter int SQUARE_EDGE  = 8,
  parameter int DEPTH_LEVELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // height_top_left, height_top_right, height_bottom_left, height_bottom_right
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red, green, blue, alpha
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int DW = $clog2(DEPTH_LEVELS);
  localparam int DMAX = DEPTH_LEVELS - 1;
  localparam int SDL = 2 * NORM_LAT + 2;
  localparam int VL = 2 * NORM_LAT + 9;

  logic [47:0] sun_direction;
  logic [35:0] sun_color;
  logic [35:0] ambient_color;
  logic [35:0] water_min_color;
  logic [35:0] water_base_color;
  logic [47:0] water_absorb;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_direction    <= '0;
      sun_color        <= '0;
      ambient_color    <= '0;
      water_min_color  <= '0;
      water_base_color <= '0;
      water_absorb     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUN_DIRECTION:    sun_direction    <= cfg_data;
        REG_SUN_COLOR:        sun_color        <= cfg_data[35:0];
        REG_AMBIENT_COLOR:    ambient_color    <= cfg_data[35:0];
        REG_WATER_MIN_COLOR:  water_min_color  <= cfg_data[35:0];
        REG_WATER_BASE_COLOR: water_base_color <= cfg_data[35:0];
        REG_WATER_ABSORB:     water_absorb     <= cfg_data;
        default: ;
      endcase
    end
  end

  unit_t       sun_c [3];
  logic [11:0] sc_c [3];
  logic [11:0] amb_c [3];
  logic [11:0] mn_c [3];
  logic [11:0] base_c [3];
  logic [15:0] ab_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sun_c[i]  = $signed(sun_direction[16*i +: 16]);
      sc_c[i]   = sun_color[12*i +: 12];
      amb_c[i]  = ambient_color[12*i +: 12];
      mn_c[i]   = water_min_color[12*i +: 12];
      base_c[i] = water_base_color[12*i +: 12];
      ab_c[i]   = water_absorb[16*i +: 16];
    end
  end

  logic ce;
  logic out_load;
  logic vld [0:VL-1];

  assign out_load = !m_tvalid || m_tready;
  assign ce = !vld[VL-1] || out_load;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VL; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < VL; k++) vld[k] <= vld[k-1];
    end
  end

  // stage 0: triangle edge vectors and center sum
  logic signed [15:0] tl, tr, bl, br;
  comp_t v1 [3];
  comp_t v2 [3];
  logic signed [17:0] sd [0:SDL-1];

  assign tl = $signed(s_tdata[15:0]);
  assign tr = $signed(s_tdata[31:16]);
  assign bl = $signed(s_tdata[47:32]);
  assign br = $signed(s_tdata[63:48]);

  always_ff @(posedge clk) begin
    if (ce) begin
      v1[0] <= comp_t'(tl) - comp_t'(tr);
      v1[1] <= comp_t'(SQUARE_EDGE * 64);
      v1[2] <= comp_t'(tl) - comp_t'(bl);
      v2[0] <= comp_t'(bl) - comp_t'(br);
      v2[1] <= comp_t'(SQUARE_EDGE * 64);
      v2[2] <= comp_t'(tr) - comp_t'(br);
      sd[0] <= 18'(tl) + 18'(tr) + 18'(bl) + 18'(br);
      for (int k = 1; k < SDL; k++) sd[k] <= sd[k-1];
    end
  end

  unit_t n1 [3];
  unit_t n2 [3];
  comp_t msum [3];
  unit_t n [3];

  tss_norm u_norm_a (.clk(clk), .ce(ce), .vin(v1), .vout(n1));
  tss_norm u_norm_b (.clk(clk), .ce(ce), .vin(v2), .vout(n2));

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) msum[i] <= comp_t'(n1[i]) + comp_t'(n2[i]);
    end
  end

  tss_norm u_norm_m (.clk(clk), .ce(ce), .vin(msum), .vout(n));

  // T2: dot products, depth, absorption
  logic signed [17:0] sc2;
  logic [9:0]         pd2;
  logic [DW-1:0]      dep2;
  logic signed [31:0] prd2 [3];
  logic [17:0]        p2;
  logic               neg2;
  logic [15+DW:0]     abd2 [3];

  always_comb begin
    sc2 = sd[SDL-1];
    pd2 = 10'($unsigned(-sc2) >> 8);
    if (13'(pd2) > 13'(DMAX)) begin
      dep2 = DW'(DMAX);
    end else begin
      dep2 = DW'(pd2);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        prd2[i] <= n[i] * sun_c[i];
        abd2[i] <= ab_c[i] * dep2;
      end
      p2   <= $unsigned(-sc2);
      neg2 <= sc2 < 0;
    end
  end

  // T3: dot sum, absorbed water color
  logic signed [33:0] dot3;
  logic [17:0]        w3 [3];
  logic [17:0]        p3;
  logic               neg3;
  logic signed [29:0] wt3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wt3[i] = $signed(30'({base_c[i], 6'b0})) - $signed(30'(abd2[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dot3 <= 34'(prd2[0]) + 34'(prd2[1]) + 34'(prd2[2]);
      for (int i = 0; i < 3; i++) begin
        if (wt3[i] < $signed(30'({mn_c[i], 6'b0}))) begin
          w3[i] <= {mn_c[i], 6'b0};
        end else begin
          w3[i] <= wt3[i][17:0];
        end
      end
      p3   <= p2;
      neg3 <= neg2;
    end
  end

  // T4: diffuse product, water byte
  logic        pos4;
  logic [42:0] dp4 [3];
  logic [7:0]  wb4 [3];
  logic [17:0] p4;
  logic        neg4;
  logic [25:0] wm4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) wm4[i] = w3[i] * LIGHT_SCALE;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pos4 <= dot3 > 0;
      for (int i = 0; i < 3; i++) begin
        dp4[i] <= sc_c[i] * dot3[30:0];
        wb4[i] <= (wm4[i][25:16] > 10'(BYTE_MAX)) ? BYTE_MAX : wm4[i][23:16];
      end
      p4   <= p3;
      neg4 <= neg3;
    end
  end

  // T5: light level
  logic [15:0] ls5 [3];
  logic [10:0] lq5 [3];
  logic [17:0] l2105 [3];
  logic [7:0]  wb5 [3];
  logic [17:0] p5;
  logic        neg5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ls5[i] = (pos4 ? 16'(dp4[i][42:28]) : 16'd0) + 16'(amb_c[i]);
      lq5[i] = (ls5[i] > 16'(LIGHT_MAX)) ? LIGHT_MAX : ls5[i][10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) l2105[i] <= 18'(lq5[i]) * 18'(LIGHT_SCALE);
      wb5  <= wb4;
      p5   <= p4;
      neg5 <= neg4;
    end
  end

  // T6: blend products
  logic        sh6;
  logic [11:0] pr6;
  logic [19:0] a6 [3];
  logic [29:0] b6 [3];
  logic [19:0] ap6;
  logic [7:0]  lb6 [3];
  logic [7:0]  wb6 [3];
  logic        neg6;
  logic        sh5;
  logic [11:0] pr5;

  always_comb begin
    sh5 = p5 < SHALLOW_LIMIT;
    pr5 = 12'(SHALLOW_LIMIT - p5);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a6[i]  <= wb5[i] * p5[11:0];
        b6[i]  <= l2105[i] * pr5;
        lb6[i] <= l2105[i][17:10];
      end
      ap6  <= pr5 * BYTE_MAX;
      pr6  <= pr5;
      sh6  <= sh5;
      wb6  <= wb5;
      neg6 <= neg5;
    end
  end

  // T7: blend sums scaled by 1/2^19, alpha by 1/2^9, ahead of the divide by five
  logic [11:0] x7 [3];
  logic [10:0] ay7;
  logic [7:0]  lb7 [3];
  logic [7:0]  wb7 [3];
  logic        sh7;
  logic        neg7;
  logic [30:0] num6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) num6[i] = 31'({a6[i], 10'b0}) + 31'(b6[i]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) x7[i] <= num6[i][30:19];
      ay7  <= ap6[19:9];
      lb7  <= lb6;
      wb7  <= wb6;
      sh7  <= sh6 && (pr6 != '0);
      neg7 <= neg6;
    end
  end

  // T8: divide by five, select case
  logic [27:0] q7 [3];
  logic [26:0] qa7;
  logic [7:0]  ch8 [3];
  logic [7:0]  al8;

  always_comb begin
    for (int i = 0; i < 3; i++) q7[i] = x7[i] * RECIP5;
    qa7 = ay7 * RECIP5;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (!neg7) begin
          ch8[i] <= lb7[i];
        end else if (sh7) begin
          ch8[i] <= q7[i][RECIP5_SHIFT +: 8];
        end else begin
          ch8[i] <= wb7[i];
        end
      end
      if (!neg7) begin
        al8 <= BYTE_MAX;
      end else if (sh7) begin
        al8 <= qa7[RECIP5_SHIFT +: 8];
      end else begin
        al8 <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= vld[VL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[VL-1]) begin
      m_tdata <= {al8, ch8[2], ch8[1], ch8[0]};
    end
  end

endmodule

// ===== src/tss_norm.sv =====
module tss_norm import tss_pkg::*; (
  input  logic  clk,
  input  logic  ce,
  input  comp_t vin [3],
  output unit_t vout [3]
);

  logic [CW-1:0]   mag0 [3];
  logic [CW-1:0]   mag1 [3];
  logic            sgn1 [3];
  logic [2*CW-1:0] sq1 [3];
  logic [35:0]     len2;

  logic [XW-1:0]  srem  [0:SQB];
  logic [SQB-1:0] sroot [0:SQB];
  logic [CW-1:0]  smag  [0:SQB][3];
  logic           ssgn  [0:SQB][3];

  logic [NW-1:0]  drem [0:QB][3];
  logic [QB-1:0]  dq   [0:QB][3];
  logic [SQB:0]   dden [0:QB];
  logic           dovf [0:QB][3];
  logic           dz   [0:QB];
  logic           dsgn [0:QB][3];

  logic [NW-1:0]  pnum [3];
  logic [QB-1:0]  qq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] = vin[i][CW-1] ? $unsigned(-vin[i]) : $unsigned(vin[i]);
    end
    len2 = 36'(sq1[0]) + 36'(sq1[1]) + 36'(sq1[2]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag0[i];
        sgn1[i] <= vin[i][CW-1];
        sq1[i]  <= mag0[i] * mag0[i];
        smag[0][i] <= mag1[i];
        ssgn[0][i] <= sgn1[i];
      end
      srem[0]  <= {len2, 16'b0};
      sroot[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar g = 0; g < SQB; g++) begin : g_sqrt
    localparam int K = SQB - 1 - g;
    logic [XW+1:0] t;
    logic [XW+1:0] r;
    always_comb begin
      t = ((XW+2)'(sroot[g]) << (K + 1)) + ((XW+2)'(1) << (2 * K));
      r = (XW+2)'(srem[g]);
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        if (r >= t) begin
          srem[g+1]  <= XW'(r - t);
          sroot[g+1] <= sroot[g] + (SQB'(1) << K);
        end else begin
          srem[g+1]  <= srem[g];
          sroot[g+1] <= sroot[g];
        end
        smag[g+1] <= smag[g];
        ssgn[g+1] <= ssgn[g];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pnum[i] = (NW'(smag[SQB][i]) << FRAC_SHIFT) + NW'(sroot[SQB]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= pnum[i];
        dq[0][i]   <= '0;
        dovf[0][i] <= pnum[i] >= (NW'({sroot[SQB], 1'b0}) << QB);
        dsgn[0][i] <= ssgn[SQB][i];
      end
      dden[0] <= {sroot[SQB], 1'b0};
      dz[0]   <= sroot[SQB] == '0;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int B = QB - 1 - g;
    logic [NW-1:0] sub;
    always_comb sub = NW'(dden[g]) << B;
    always_ff @(posedge clk) begin
      if (ce) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[g][i] >= sub) begin
            drem[g+1][i] <= drem[g][i] - sub;
            dq[g+1][i]   <= dq[g][i] | (QB'(1) << B);
          end else begin
            drem[g+1][i] <= drem[g][i];
            dq[g+1][i]   <= dq[g][i];
          end
        end
        dden[g+1] <= dden[g];
        dovf[g+1] <= dovf[g];
        dz[g+1]   <= dz[g];
        dsgn[g+1] <= dsgn[g];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz[QB]) begin
        qq[i] = '0;
      end else if (dovf[QB][i] || dq[QB][i] > UNIT_Q14) begin
        qq[i] = UNIT_Q14;
      end else begin
        qq[i] = dq[QB][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        vout[i] <= dsgn[QB][i] ? unit_t'(-{1'b0, qq[i]}) : unit_t'({1'b0, qq[i]});
      end
    end
  end

endmodule

// ===== dv/terrain_square_shader_tb.sv =====
module terrain_square_shader_tb;
  import tss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE_LEN = 8;
  localparam int DEPTH_MAX = 1024;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  logic [47:0] sun_dir;
  logic [35:0] sun_col, amb_col, wmin_col, wbase_col;
  logic [47:0] absorb;

  logic [31:0] pixel_q[$];
  int          errors = 0;
  bit          idle_on;

  terrain_square_shader #(.SQUARE_EDGE(EDGE_LEN), .DEPTH_LEVELS(DEPTH_MAX)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic unit_vec(input longint v0, v1, v2, output longint o0, o1, o2);
    longint vv[3];
    longint oo[3];
    longint unsigned len2, len, m, q;
    vv[0] = v0; vv[1] = v1; vv[2] = v2;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      m = vv[i] < 0 ? -vv[i] : vv[i];
      len2 += m * m;
    end
    len = isqrt(len2 << 16);
    for (int i = 0; i < 3; i++) begin
      m = vv[i] < 0 ? -vv[i] : vv[i];
      if (len == 0) begin
        oo[i] = 0;
      end else begin
        q = ((m << 23) + len) / (2 * len);
        if (q > 16384) q = 16384;
        oo[i] = vv[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    o0 = oo[0]; o1 = oo[1]; o2 = oo[2];
  endtask

  task automatic shade_square(input logic [63:0] hw, output logic [31:0] px);
    longint tl, tr, bl, br, s, a0, a1, a2, b0, b1, b2, n0, n1, n2, dot;
    longint unsigned lt[3], sc, amb, diff, lq, p, d, wb, num;
    longint mn, base, ab, w;
    logic [7:0] ch[4];
    tl = longint'(signed'(hw[15:0]));
    tr = longint'(signed'(hw[31:16]));
    bl = longint'(signed'(hw[47:32]));
    br = longint'(signed'(hw[63:48]));
    s = tl + tr + bl + br;
    unit_vec(tl - tr, EDGE_LEN * 64, tl - bl, a0, a1, a2);
    unit_vec(bl - br, EDGE_LEN * 64, tr - br, b0, b1, b2);
    unit_vec(a0 + b0, a1 + b1, a2 + b2, n0, n1, n2);
    dot = n0 * longint'(signed'(sun_dir[15:0])) + n1 * longint'(signed'(sun_dir[31:16]))
        + n2 * longint'(signed'(sun_dir[47:32]));
    for (int i = 0; i < 3; i++) begin
      sc = 64'(sun_col[12*i +: 12]);
      amb = 64'(amb_col[12*i +: 12]);
      diff = dot > 0 ? (sc * longint'(dot)) >> 28 : 0;
      lq = diff + amb;
      if (lq > 1024) lq = 1024;
      lt[i] = lq * 210;
    end
    if (s >= 0) begin
      for (int i = 0; i < 3; i++) ch[i] = 8'(lt[i] >> 10);
      ch[3] = 8'd255;
    end else begin
      p = -s;
      d = p >> 8;
      if (d > DEPTH_MAX - 1) d = DEPTH_MAX - 1;
      for (int i = 0; i < 3; i++) begin
        mn = longint'(wmin_col[12*i +: 12]) * 64;
        base = longint'(wbase_col[12*i +: 12]) * 64;
        ab = longint'(absorb[16*i +: 16]);
        w = base - ab * longint'(d);
        if (w < mn) w = mn;
        wb = (longint'(w) * 210) >> 16;
        if (wb > 255) wb = 255;
        if (p < 2560) begin
          num = wb * p * 1024 + lt[i] * (2560 - p);
          ch[i] = 8'(num / (64'd2560 * 1024));
        end else begin
          ch[i] = 8'(wb);
        end
      end
      ch[3] = p < 2560 ? 8'((2560 - p) * 255 / 2560) : 8'd0;
    end
    px = {ch[3], ch[2], ch[1], ch[0]};
  endtask

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_square(input logic [63:0] hw);
    logic [31:0] px;
    idle_gap();
    shade_square(hw, px);
    pixel_q.push_back(px);
    s_tvalid <= 1'b1;
    s_tdata  <= hw;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_heights(input int h0, h1, h2, h3);
    send_square({h3[15:0], h2[15:0], h1[15:0], h0[15:0]});
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SUN_DIRECTION:    sun_dir   = val;
      REG_SUN_COLOR:        sun_col   = val[35:0];
      REG_AMBIENT_COLOR:    amb_col   = val[35:0];
      REG_WATER_MIN_COLOR:  wmin_col  = val[35:0];
      REG_WATER_BASE_COLOR: wbase_col = val[35:0];
      REG_WATER_ABSORB:     absorb    = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic load_config(input int mode);
    drain();
    case (mode)
      0: begin
        // straight up sun, white light, moderate water
        write_reg(REG_SUN_DIRECTION, {16'sd0, 16'sd16384, 16'sd0});
        write_reg(REG_SUN_COLOR, 48'({3{12'd800}}));
        write_reg(REG_AMBIENT_COLOR, 48'({12'd100, 12'd200, 12'd300}));
        write_reg(REG_WATER_MIN_COLOR, 48'({12'd50, 12'd100, 12'd150}));
        write_reg(REG_WATER_BASE_COLOR, 48'({12'd600, 12'd800, 12'd1000}));
        write_reg(REG_WATER_ABSORB, {16'd3000, 16'd2000, 16'd1000});
      end
      1: begin
        write_reg(REG_SUN_DIRECTION, '1);
        write_reg(REG_SUN_COLOR, '1);
        write_reg(REG_AMBIENT_COLOR, '1);
        write_reg(REG_WATER_MIN_COLOR, '1);
        write_reg(REG_WATER_BASE_COLOR, '1);
        write_reg(REG_WATER_ABSORB, '1);
      end
      2: begin
        write_reg(REG_SUN_DIRECTION, {16'sh8000, 16'sh7fff, 16'sh8000});
        write_reg(REG_SUN_COLOR, '1);
        write_reg(REG_AMBIENT_COLOR, '0);
        write_reg(REG_WATER_MIN_COLOR, '0);
        write_reg(REG_WATER_BASE_COLOR, '1);
        write_reg(REG_WATER_ABSORB, '0);
      end
      default: begin
        write_reg(REG_SUN_DIRECTION, rnd48());
        write_reg(REG_SUN_COLOR, rnd48());
        write_reg(REG_AMBIENT_COLOR, {36'($urandom_range(0, 600)), 12'($urandom())});
        write_reg(REG_WATER_MIN_COLOR, rnd48());
        write_reg(REG_WATER_BASE_COLOR, rnd48());
        write_reg(REG_WATER_ABSORB, {16'($urandom_range(0, 65535)), $urandom()});
      end
    endcase
  endtask

  task automatic test_directed();
    load_config(0);
    send_heights(0, 0, 0, 0);
    send_heights(32767, 32767, 32767, 32767);
    send_heights(-32768, -32768, -32768, -32768);
    send_heights(32767, -32768, 32767, -32768);
    send_heights(-32768, 32767, 32767, -32768);
    send_heights(100, -50, 20, -70);
    send_heights(-1, 0, 0, 0);
    send_heights(-160, -160, -160, -160);
    send_heights(-160, -160, -160, -159);
    send_heights(-640, -640, -640, -640);
    send_heights(-300, -200, -100, 50);
    send_heights(-20000, -30000, -25000, -32768);
    send_heights(5000, -5000, 0, 0);
    send_heights(0, 0, 5000, -5000);
    load_config(1);
    send_heights(0, 0, 0, 0);
    send_heights(-100, -120, -90, -80);
    send_heights(-32768, -32768, -32768, -32768);
    send_heights(-800, -800, -800, -800);
    load_config(2);
    send_heights(1000, 0, 0, -1000);
    send_heights(-1000, 1000, -1000, 1000);
    send_heights(-500, -700, -600, -400);
    send_heights(-32768, 0, 0, 0);
  endtask

  task automatic random_square();
    int h0, h1, h2, h3, k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      // near the shoreline: shallow water blend and its edges
      h0 = $urandom_range(0, 1400) - 900;
      h1 = h0 + $urandom_range(0, 200) - 100;
      h2 = h0 + $urandom_range(0, 200) - 100;
      h3 = h0 + $urandom_range(0, 200) - 100;
    end else if (k < 7) begin
      h0 = $urandom_range(0, 20000) - 10000;
      h1 = h0 + $urandom_range(0, 4000) - 2000;
      h2 = h0 + $urandom_range(0, 4000) - 2000;
      h3 = h0 + $urandom_range(0, 4000) - 2000;
    end else begin
      h0 = $urandom(); h1 = $urandom(); h2 = $urandom(); h3 = $urandom();
    end
    send_heights(h0, h1, h2, h3);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      load_config(ph < 2 ? ph : 3);
      for (int n = 0; n < 150; n++) random_square();
    end
  endtask

  task automatic test_full_rate();
    drain();
    idle_on = 1'b0;
    load_config(3);
    for (int n = 0; n < 225; n++) random_square();
  endtask

  initial begin
    m_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_tdata);
        errors++;
      end else begin
        logic [31:0] want;
        want = pixel_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (want[8*i +: 8] !== m_tdata[8*i +: 8]) begin
            $display("%0t: channel %0d expected %0d actual %0d", $time, i,
                     want[8*i +: 8], m_tdata[8*i +: 8]);
            errors++;
          end
      end
    end
  end

  initial begin
    idle_on   = 1'b1;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sun_dir = '0; sun_col = '0; amb_col = '0;
    wmin_col = '0; wbase_col = '0; absorb = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values: all registers zero
    send_heights(-100, -200, 300, 0);
    send_heights(200, 100, 0, 50);
    test_directed();
    test_random();
    test_full_rate();
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tss_pkg.sv
src/tss_norm.sv
src/terrain_square_shader.sv
dv/terrain_square_shader_tb.sv
